FILE: design/lru_key_value_cache_assert.svh
// ----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Shared property wrappers for the cache's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LKVC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lkvc: same-cycle check failed");

// next-cycle implication, disabled during reset
`define LKVC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lkvc: next-cycle check failed");

`endif

FILE: design/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Sizes, payload structs, state and command types shared by the cache.
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

  localparam int unsigned ENTRIES   = 16;
  localparam int unsigned IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned RANK_W    = IDX_W;
  localparam int unsigned CNT_W     = $clog2(ENTRIES + 1);
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned VAL_W     = 64;
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned CAP_RESET = 16;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_SET = 1'b1
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
    logic                    evicted;
  } out_item_t;

  // one stored entry in the key/value memory
  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  typedef enum logic [1:0] {
    LRU_NONE,
    LRU_TOUCH,
    LRU_INSERT
  } lru_op_e;

  typedef struct packed {
    lru_op_e           op;
    logic [IDX_W-1:0]  slot;
    logic [RANK_W-1:0] rank;   // rank of slot before a touch
    logic              evict;  // insert replaces a valid entry
  } lru_cmd_t;

  typedef struct packed {
    logic              valid;
    logic [RANK_W-1:0] rank;
    logic [CNT_W-1:0]  occ;
  } lru_stat_t;

endpackage

`default_nettype wire

FILE: design/lkvc_ram.sv
// ----------------------------------------------------------------------------
// LKVC simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

FILE: design/lkvc_lru.sv
// ----------------------------------------------------------------------------
// LKVC recency tracker
// Valid flags, recency ranks and occupancy; touch and insert updates.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_lru
  import lkvc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire lru_cmd_t         cmd_i,
  input  wire logic [IDX_W-1:0] scan_idx_i,
  output lru_stat_t             stat_o
);

  logic              valid_q [ENTRIES];
  logic              valid_d [ENTRIES];
  logic [RANK_W-1:0] rank_q  [ENTRIES];
  logic [RANK_W-1:0] rank_d  [ENTRIES];
  logic [CNT_W-1:0]  occ_q, occ_d;

  always_comb begin
    occ_d = occ_q;
    for (int i = 0; i < ENTRIES; i++) begin
      valid_d[i] = valid_q[i];
      rank_d[i]  = rank_q[i];
      unique case (cmd_i.op)
        LRU_TOUCH: begin
          // entries more recent than the touched one age by one
          if (IDX_W'(i) == cmd_i.slot) begin
            rank_d[i] = '0;
          end else if (valid_q[i] && (rank_q[i] < cmd_i.rank)) begin
            rank_d[i] = rank_q[i] + RANK_W'(1);
          end
        end
        LRU_INSERT: begin
          if (IDX_W'(i) == cmd_i.slot) begin
            valid_d[i] = 1'b1;
            rank_d[i]  = '0;
          end else if (valid_q[i]) begin
            rank_d[i] = rank_q[i] + RANK_W'(1);
          end
        end
        default: ;
      endcase
    end
    if ((cmd_i.op == LRU_INSERT) && !cmd_i.evict) begin
      occ_d = occ_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        valid_q[i] <= 1'b0;
        rank_q[i]  <= '0;
      end
      occ_q <= '0;
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        valid_q[i] <= valid_d[i];
        rank_q[i]  <= rank_d[i];
      end
      occ_q <= occ_d;
    end
  end

  assign stat_o.valid = valid_q[scan_idx_i];
  assign stat_o.rank  = rank_q[scan_idx_i];
  assign stat_o.occ   = occ_q;

endmodule

`default_nettype wire

FILE: design/lru_key_value_cache.sv
// A new item is taken only once the current one's update has fired; the key
//   memory's single read port is scanned one entry per cycle before the update.
// Reset: valid flags, recency ranks and occupancy clear at once, capacity returns
//   to 16; key/value memory contents are left as they are (no clearing pass).
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative get/set store with least-recently-used replacement.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lru_key_value_cache_assert.svh"

module lru_key_value_cache
  import lkvc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // configuration: capacity register
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CFG_W-1:0] cfg_wdata_i,
  // request channel
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire in_item_t         in_data_i,
  // result channel
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output out_item_t             out_data_o
);

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  state_e            state_q, state_d;
  logic [IDX_W-1:0]  cnt_q;        // index whose memory data is on rd_data
  in_item_t          item_q;
  logic [CFG_W-1:0]  cap_q;

  // scan results
  logic              found_q;
  logic [IDX_W-1:0]  found_idx_q;
  logic [RANK_W-1:0] found_rank_q;
  logic [VAL_W-1:0]  found_val_q;
  logic              have_victim_q;
  logic [IDX_W-1:0]  victim_q;
  logic [RANK_W-1:0] victim_rank_q;
  logic              have_free_q;
  logic [IDX_W-1:0]  free_q;

  // output register
  logic              out_valid_q;
  out_item_t         out_q;

  // memory and tracker hookup
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  entry_t            rd_data;
  logic              we;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;
  lru_cmd_t          lru_cmd;
  lru_stat_t         stat;

  logic              in_xfer;
  logic              upd_fire;
  logic              scan_last;
  logic              match;
  logic [CNT_W-1:0]  eff_cap;
  logic              evict;
  logic              ins;
  out_item_t         result;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // the update waits only for the output register to be free
  assign upd_fire  = (state_q == ST_UPDATE) && !(out_valid_q && out_stall_i);
  assign scan_last = (cnt_q == IDX_W'(ENTRIES - 1));
  assign match     = stat.valid && (rd_data.key == item_q.key);

  // capacity clamps to 1..ENTRIES
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CNT_W'(1);
    end else if (32'(cap_q) > ENTRIES) begin
      eff_cap = CNT_W'(ENTRIES);
    end else begin
      eff_cap = CNT_W'(cap_q);
    end
  end

  // a set that misses inserts; it evicts when occupancy has reached capacity
  assign ins   = !found_q && (item_q.op == OP_SET);
  assign evict = ins && (stat.occ >= eff_cap);

  // --------------------------------------------------------------------------
  // Key/value memory and recency tracker
  // --------------------------------------------------------------------------
  lkvc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  lkvc_lru u_lru (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (lru_cmd),
    .scan_idx_i (cnt_q),
    .stat_o     (stat)
  );

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_xfer)   state_d = ST_SCAN;
      ST_SCAN:   if (scan_last) state_d = ST_UPDATE;
      ST_UPDATE: if (upd_fire)  state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Outputs of the sequencer: memory ports, tracker command, result
  // --------------------------------------------------------------------------
  always_comb begin
    rd_en        = 1'b0;
    rd_addr      = '0;
    we           = 1'b0;
    wr_addr      = found_idx_q;
    wr_data.key   = item_q.key;
    wr_data.value = item_q.value;
    lru_cmd.op    = LRU_NONE;
    lru_cmd.slot  = found_idx_q;
    lru_cmd.rank  = found_rank_q;
    lru_cmd.evict = evict;
    unique case (state_q)
      ST_IDLE: begin
        // entry 0 is fetched on the transfer edge
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      ST_SCAN: begin
        rd_en   = !scan_last;
        rd_addr = cnt_q + IDX_W'(1);
      end
      ST_UPDATE: begin
        if (upd_fire) begin
          if (found_q) begin
            lru_cmd.op = LRU_TOUCH;
            we         = (item_q.op == OP_SET);
          end else if (ins) begin
            lru_cmd.op   = LRU_INSERT;
            lru_cmd.slot = evict ? victim_q : free_q;
            wr_addr      = evict ? victim_q : free_q;
            we           = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    result.hit        = found_q;
    result.read_value = (found_q && (item_q.op == OP_GET)) ? found_val_q : '0;
    result.evicted    = evict;
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CFG_W'(CAP_RESET);
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_wdata_i;
      end
      if (upd_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload and scan bookkeeping
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q        <= in_data_i;
      cnt_q         <= '0;
      found_q       <= 1'b0;
      have_victim_q <= 1'b0;
      have_free_q   <= 1'b0;
    end else if (state_q == ST_SCAN) begin
      cnt_q <= cnt_q + IDX_W'(1);
      if (match) begin
        found_q      <= 1'b1;
        found_idx_q  <= cnt_q;
        found_rank_q <= stat.rank;
        found_val_q  <= rd_data.value;
      end
      // oldest valid entry so far is the eviction candidate
      if (stat.valid && (!have_victim_q || (stat.rank > victim_rank_q))) begin
        have_victim_q <= 1'b1;
        victim_q      <= cnt_q;
        victim_rank_q <= stat.rank;
      end
      // lowest-numbered empty slot
      if (!stat.valid && !have_free_q) begin
        have_free_q <= 1'b1;
        free_q      <= cnt_q;
      end
    end
    if (upd_fire) begin
      out_q <= result;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `LKVC_ASSERT_NEXT(a_xfer_starts_scan, clk_i, rst_ni, in_xfer,
                    (state_q == ST_SCAN) && (cnt_q == '0))
  `LKVC_ASSERT_NEXT(a_update_loads_out, clk_i, rst_ni, upd_fire,
                    out_valid_q && (state_q == ST_IDLE))
  `LKVC_ASSERT_NOW(a_evict_has_victim, clk_i, rst_ni, upd_fire && evict, have_victim_q)
  `LKVC_ASSERT_NOW(a_insert_has_free, clk_i, rst_ni, upd_fire && ins && !evict, have_free_q)
  `LKVC_ASSERT_NOW(a_occ_bounded, clk_i, rst_ni, 1'b1, 32'(stat.occ) <= ENTRIES)

endmodule

`default_nettype wire
